// ----- sv/assert_macros.svh -----
// Assertion macros used by the vector angle RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, also checked during reset.
`define ASSERT_PROP_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/tcva_pkg.sv -----
// Constants, types and the correction ROM for the vector angle pipeline.
`default_nettype none

package tcva_pkg;

  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int MAG_W      = COORD_W;
  localparam int ANGLE_FRAC = 7;
  localparam int RATIO_FRAC = 24;
  localparam int Q_W        = RATIO_FRAC + 1;     // ratio quotient bits, ratio <= 1.0
  localparam int IDX_W      = 7;                  // ROM index, 0..90
  localparam int ROM_DEPTH  = 91;
  localparam int NUM_W      = MAG_W + 8;          // 180 * small + large
  localparam int IREM_W     = MAG_W + 1;
  localparam int FACT_W     = 24;
  localparam int PROD_W     = Q_W + FACT_W;
  localparam int C_W        = Q_W + 1;            // corrected ratio, below 1.28 in Q24
  localparam int T_W        = C_W + 6 + ANGLE_FRAC;
  localparam int R_W        = T_W - RATIO_FRAC;
  localparam int HEAD_W     = 16;
  localparam int H_W        = HEAD_W + 1;

  // 10^7 = 2^7 * 5^7: shift off 2^7, then multiply by ceil(2^58 / 5^7)
  localparam int DIV_PRE     = 7;
  localparam int M_W         = PROD_W - DIV_PRE;  // 42
  localparam int HALF_W      = M_W / 2;           // partial product operand width
  localparam int RECIP_W     = 2 * HALF_W;
  localparam int PP_W        = 2 * HALF_W;
  localparam int SUM_W       = M_W + RECIP_W;
  localparam int RECIP_SHIFT = 58;                // SUM_W - RECIP_SHIFT == C_W

  // front end 4, ratio divider, ROM 1, multiply 1, scale 4, offset 1, placement 1
  localparam int LATENCY    = Q_W + 12;

  localparam logic [FACT_W-1:0]  FACTOR_ONE = FACT_W'(10000000);
  localparam logic [FACT_W-1:0]  FACTOR_HALF = FACT_W'(5000000);
  localparam logic [RECIP_W-1:0] RECIP_5P7 = 42'd3689348814742;
  localparam logic [T_W-1:0]     OFFSET_SCALE = T_W'(45 * (2 ** ANGLE_FRAC));
  localparam logic [T_W-1:0]     OFFSET_ROUND = T_W'(2 ** (RATIO_FRAC - 1));

  localparam logic [H_W-1:0] DEG90  = H_W'(90 * (2 ** ANGLE_FRAC));
  localparam logic [H_W-1:0] DEG180 = H_W'(180 * (2 ** ANGLE_FRAC));
  localparam logic [H_W-1:0] DEG270 = H_W'(270 * (2 ** ANGLE_FRAC));
  localparam logic [H_W-1:0] DEG360 = H_W'(360 * (2 ** ANGLE_FRAC));
  localparam logic [H_W-1:0] HEADING_MAX = H_W'(360 * (2 ** ANGLE_FRAC) - 1);

  typedef struct packed {
    logic sel_x;   // |dx| > |dy|
    logic dx_neg;
    logic dy_neg;
    logic zero;    // coincident points
  } ctl_t;

  // Correction factors scaled by 10^7; out-of-range index reads as unity.
  function automatic logic [FACT_W-1:0] tcva_factor(input logic [IDX_W-1:0] idx);
    logic [FACT_W-1:0] f;
    case (idx)
      7'd0:  f = 24'd10000000;  7'd1:  f = 24'd12731870;  7'd2:  f = 24'd12730300;
      7'd3:  f = 24'd12727680;  7'd4:  f = 24'd12724020;  7'd5:  f = 24'd12719320;
      7'd6:  f = 24'd12713580;  7'd7:  f = 24'd12706810;  7'd8:  f = 24'd12699020;
      7'd9:  f = 24'd12690210;  7'd10: f = 24'd12680380;  7'd11: f = 24'd12669560;
      7'd12: f = 24'd12657740;  7'd13: f = 24'd12644939;  7'd14: f = 24'd12631160;
      7'd15: f = 24'd12616431;  7'd16: f = 24'd12600750;  7'd17: f = 24'd12584130;
      7'd18: f = 24'd12566590;  7'd19: f = 24'd12548150;  7'd20: f = 24'd12528811;
      7'd21: f = 24'd12508590;  7'd22: f = 24'd12487520;  7'd23: f = 24'd12465600;
      7'd24: f = 24'd12442850;  7'd25: f = 24'd12419291;  7'd26: f = 24'd12394940;
      7'd27: f = 24'd12369810;  7'd28: f = 24'd12343930;  7'd29: f = 24'd12317311;
      7'd30: f = 24'd12289970;  7'd31: f = 24'd12261920;  7'd32: f = 24'd12233200;
      7'd33: f = 24'd12203820;  7'd34: f = 24'd12173790;  7'd35: f = 24'd12143151;
      7'd36: f = 24'd12111890;  7'd37: f = 24'd12080060;  7'd38: f = 24'd12047660;
      7'd39: f = 24'd12014710;  7'd40: f = 24'd11981241;  7'd41: f = 24'd11947269;
      7'd42: f = 24'd11912810;  7'd43: f = 24'd11877871;  7'd44: f = 24'd11842500;
      7'd45: f = 24'd11806690;  7'd46: f = 24'd11770470;  7'd47: f = 24'd11733860;
      7'd48: f = 24'd11696870;  7'd49: f = 24'd11659520;  7'd50: f = 24'd11621840;
      7'd51: f = 24'd11583840;  7'd52: f = 24'd11545531;  7'd53: f = 24'd11506931;
      7'd54: f = 24'd11468060;  7'd55: f = 24'd11428930;  7'd56: f = 24'd11389570;
      7'd57: f = 24'd11349980;  7'd58: f = 24'd11310180;  7'd59: f = 24'd11270190;
      7'd60: f = 24'd11230021;  7'd61: f = 24'd11189690;  7'd62: f = 24'd11149200;
      7'd63: f = 24'd11108580;  7'd64: f = 24'd11067830;  7'd65: f = 24'd11026970;
      7'd66: f = 24'd10986010;  7'd67: f = 24'd10944960;  7'd68: f = 24'd10903840;
      7'd69: f = 24'd10862660;  7'd70: f = 24'd10821420;  7'd71: f = 24'd10780140;
      7'd72: f = 24'd10738831;  7'd73: f = 24'd10697500;  7'd74: f = 24'd10656160;
      7'd75: f = 24'd10614820;  7'd76: f = 24'd10573480;  7'd77: f = 24'd10532160;
      7'd78: f = 24'd10490870;  7'd79: f = 24'd10449600;  7'd80: f = 24'd10408380;
      7'd81: f = 24'd10367210;  7'd82: f = 24'd10326101;  7'd83: f = 24'd10285040;
      7'd84: f = 24'd10244060;  7'd85: f = 24'd10203160;  7'd86: f = 24'd10162340;
      7'd87: f = 24'd10121599;  7'd88: f = 24'd10080971;  7'd89: f = 24'd10040430;
      default: f = FACTOR_ONE;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ----- sv/table_corrected_vector_angle.sv -----
// Pipelined heading from one point to another with table-corrected ratio.
//
//  channel   direction  handshake          payload
//  command   in         start_i / busy_o   from_x_i, from_y_i, to_x_i, to_y_i
//  result    out        done_o             heading_o
//
// One transfer in per cycle; busy_o never rises.
// The pipeline holds four front-end stages, the 25-stage one-bit-per-stage
// ratio divider (the ROM index divider runs beside it), ROM and multiply,
// four stages for the scale by 1e7, offset and placement.
// Reset clears only the valid bits; the receiver cannot stall.
`default_nettype none
`include "assert_macros.svh"

module table_corrected_vector_angle import tcva_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [COORD_W-1:0] from_x_i,
  input  logic signed [COORD_W-1:0] from_y_i,
  input  logic signed [COORD_W-1:0] to_x_i,
  input  logic signed [COORD_W-1:0] to_y_i,
  output logic                      done_o,
  output logic        [HEAD_W-1:0]  heading_o
);

  logic [LATENCY-1:0] vld_q;

  // stage A: differences
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  // stage B: magnitudes
  logic [MAG_W-1:0] ax_q, ay_q;
  logic             dxn_q, dyn_q;
  // stage C: octant select
  logic [MAG_W-1:0] small_q, large_q;
  ctl_t             ctl_c_q;
  // ratio and index dividers
  logic [MAG_W-1:0]  qrem_q [0:Q_W-1];
  logic [Q_W-1:0]    qlow_q [0:Q_W-1];
  logic [Q_W-1:0]    qquo_q [0:Q_W];
  logic [MAG_W-1:0]  dvs_q  [0:Q_W-1];
  logic [IREM_W-1:0] irem_q [0:IDX_W-1];
  logic [IDX_W-1:0]  ilow_q [0:IDX_W-1];
  logic [IDX_W-1:0]  iquo_q [0:Q_W];
  ctl_t              qctl_q [0:Q_W];
  // ROM and multiply
  logic [Q_W-1:0]    qr_q;
  logic [FACT_W-1:0] fac_q;
  ctl_t              ctl_r_q;
  logic [PROD_W-1:0] prod_q;
  ctl_t              ctl_m_q;
  // divide by 1e7
  logic [M_W-1:0]    mdiv_q;
  ctl_t              ctl_d_q;
  logic [PP_W-1:0]   hh_q, hl_q, lh_q, ll_q;
  ctl_t              ctl_p_q;
  logic [PP_W:0]     mid_q;
  logic [PP_W-1:0]   hh_s_q, ll_s_q;
  ctl_t              ctl_s_q;
  logic [C_W-1:0]    c_q;
  ctl_t              ctl_n_q;
  // offset and output
  logic [R_W-1:0]    r_q;
  ctl_t              ctl_t_q;
  logic [HEAD_W-1:0] heading_q;

  logic              accept;
  logic [DIFF_W-1:0] ax_full, ay_full;
  logic [NUM_W-1:0]  num_idx;
  logic [PROD_W-1:0] csum;
  logic [SUM_W-1:0]  qsum;
  logic [T_W-1:0]    tprod;
  logic [H_W-1:0]    rr, h_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], accept};
    end
  end

  // front end
  assign ax_full = dx_q[DIFF_W-1] ? -dx_q : dx_q;
  assign ay_full = dy_q[DIFF_W-1] ? -dy_q : dy_q;
  assign num_idx = NUM_W'(small_q) * NUM_W'(180) + NUM_W'(large_q);

  always_ff @(posedge clk_i) begin
    dx_q    <= DIFF_W'(to_x_i) - DIFF_W'(from_x_i);
    dy_q    <= DIFF_W'(to_y_i) - DIFF_W'(from_y_i);
    ax_q    <= ax_full[MAG_W-1:0];
    ay_q    <= ay_full[MAG_W-1:0];
    dxn_q   <= dx_q[DIFF_W-1];
    dyn_q   <= dy_q[DIFF_W-1];
    ctl_c_q <= '{sel_x:  ax_q > ay_q,
                 dx_neg: dxn_q,
                 dy_neg: dyn_q,
                 zero:   (ax_q == '0) && (ay_q == '0)};
    small_q <= (ax_q > ay_q) ? ay_q : ax_q;
    large_q <= (ax_q > ay_q) ? ax_q : ay_q;
    // divider entry: small << 24 over large, (180*small + large) over 2*large
    qrem_q[0] <= {1'b0, small_q[MAG_W-1:1]};
    qlow_q[0] <= {small_q[0], {RATIO_FRAC{1'b0}}};
    qquo_q[0] <= '0;
    dvs_q[0]  <= large_q;
    irem_q[0] <= num_idx[NUM_W-1:IDX_W];
    ilow_q[0] <= num_idx[IDX_W-1:0];
    iquo_q[0] <= '0;
    qctl_q[0] <= ctl_c_q;
  end

  // restoring dividers, one quotient bit per stage
  for (genvar k = 1; k <= Q_W; k++) begin : g_qdiv
    logic [MAG_W:0] qsh, qdif;
    logic           qge;

    assign qsh  = {qrem_q[k-1], qlow_q[k-1][Q_W-1]};
    assign qdif = qsh - {1'b0, dvs_q[k-1]};
    assign qge  = qsh >= {1'b0, dvs_q[k-1]};

    always_ff @(posedge clk_i) begin
      qquo_q[k] <= {qquo_q[k-1][Q_W-2:0], qge};
      qctl_q[k] <= qctl_q[k-1];
    end

    if (k < Q_W) begin : g_rem
      always_ff @(posedge clk_i) begin
        qrem_q[k] <= qge ? qdif[MAG_W-1:0] : qsh[MAG_W-1:0];
        qlow_q[k] <= {qlow_q[k-1][Q_W-2:0], 1'b0};
        dvs_q[k]  <= dvs_q[k-1];
      end
    end

    if (k <= IDX_W) begin : g_idx
      logic [IREM_W:0] ish, idif, idvs;
      logic            ige;

      assign idvs = {1'b0, dvs_q[k-1], 1'b0};
      assign ish  = {irem_q[k-1], ilow_q[k-1][IDX_W-1]};
      assign idif = ish - idvs;
      assign ige  = ish >= idvs;

      always_ff @(posedge clk_i) begin
        iquo_q[k] <= {iquo_q[k-1][IDX_W-2:0], ige};
      end

      if (k < IDX_W) begin : g_irem
        always_ff @(posedge clk_i) begin
          irem_q[k] <= ige ? idif[IREM_W-1:0] : ish[IREM_W-1:0];
          ilow_q[k] <= {ilow_q[k-1][IDX_W-2:0], 1'b0};
        end
      end
    end else begin : g_idx_hold
      always_ff @(posedge clk_i) begin
        iquo_q[k] <= iquo_q[k-1];
      end
    end
  end

  // ROM, multiply and rounding bias
  assign csum = prod_q + PROD_W'(FACTOR_HALF);
  // floor(csum / 1e7): drop 2^7, then multiply by the rounded-up reciprocal
  // of 5^7 as four 21 x 21 partial products; exact over the whole csum range
  assign qsum = {hh_s_q, ll_s_q} + (SUM_W'(mid_q) << HALF_W);

  always_ff @(posedge clk_i) begin
    qr_q    <= qquo_q[Q_W];
    fac_q   <= tcva_factor(iquo_q[Q_W]);
    ctl_r_q <= qctl_q[Q_W];
    prod_q  <= PROD_W'(qr_q) * PROD_W'(fac_q);
    ctl_m_q <= ctl_r_q;
    mdiv_q  <= csum[PROD_W-1:DIV_PRE];
    ctl_d_q <= ctl_m_q;
    hh_q    <= PP_W'(mdiv_q[M_W-1:HALF_W]) * PP_W'(RECIP_5P7[RECIP_W-1:HALF_W]);
    hl_q    <= PP_W'(mdiv_q[M_W-1:HALF_W]) * PP_W'(RECIP_5P7[HALF_W-1:0]);
    lh_q    <= PP_W'(mdiv_q[HALF_W-1:0]) * PP_W'(RECIP_5P7[RECIP_W-1:HALF_W]);
    ll_q    <= PP_W'(mdiv_q[HALF_W-1:0]) * PP_W'(RECIP_5P7[HALF_W-1:0]);
    ctl_p_q <= ctl_d_q;
    mid_q   <= (PP_W + 1)'(hl_q) + (PP_W + 1)'(lh_q);
    hh_s_q  <= hh_q;
    ll_s_q  <= ll_q;
    ctl_s_q <= ctl_p_q;
    c_q     <= qsum[SUM_W-1:RECIP_SHIFT];
    ctl_n_q <= ctl_s_q;
  end

  // offset r = round(45 * c * 2^frac / 2^24), then quadrant placement
  assign tprod = T_W'(c_q) * OFFSET_SCALE + OFFSET_ROUND;
  assign rr    = H_W'(r_q);

  always_comb begin
    h_d = '0;
    if (ctl_t_q.zero) begin
      h_d = '0;
    end else if (ctl_t_q.sel_x) begin
      if (!ctl_t_q.dx_neg) begin
        h_d = ctl_t_q.dy_neg ? DEG90 - rr : DEG90 + rr;
      end else begin
        h_d = ctl_t_q.dy_neg ? DEG270 + rr : DEG270 - rr;
      end
    end else begin
      if (!ctl_t_q.dy_neg) begin
        h_d = ctl_t_q.dx_neg ? DEG180 + rr : DEG180 - rr;
      end else begin
        h_d = ctl_t_q.dx_neg ? DEG360 - rr : rr;
      end
    end
    if (h_d >= DEG360) begin
      h_d = HEADING_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q       <= tprod[T_W-1:RATIO_FRAC];
    ctl_t_q   <= ctl_n_q;
    heading_q <= h_d[HEAD_W-1:0];
  end

  assign done_o    = vld_q[LATENCY-1];
  assign heading_o = heading_q;

  `ASSERT_PROP(a_fixed_latency, clk_i, rst_ni, accept |-> ##LATENCY done_o, "result strobe missing after accepted transfer")
  `ASSERT_PROP(a_coincident_zero, clk_i, rst_ni, accept && (from_x_i == to_x_i) && (from_y_i == to_y_i) |-> ##LATENCY (heading_o == '0), "coincident points must give heading zero")
  `ASSERT_PROP_NR(a_heading_range, clk_i, done_o |-> (H_W'(heading_o) <= HEADING_MAX), "heading beyond full turn")

endmodule

`default_nettype wire

// ----- verif/table_corrected_vector_angle_test.sv -----
// Self-checking testbench for the table-corrected vector heading pipeline.
`timescale 1ns / 1ps

module table_corrected_vector_angle_test import tcva_pkg::*; ;

  typedef struct {
    logic signed [COORD_W-1:0] fx;
    logic signed [COORD_W-1:0] fy;
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    bit                        known;
    logic        [HEAD_W-1:0]  heading;
  } cmd_row_t;

  localparam int NUM_DIRECTED  = 25;
  localparam int RANDOM_PHASE  = 190;
  localparam int NUM_PHASES    = 4;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic signed [COORD_W-1:0] from_x_i = '0;
  logic signed [COORD_W-1:0] from_y_i = '0;
  logic signed [COORD_W-1:0] to_x_i = '0;
  logic signed [COORD_W-1:0] to_y_i = '0;
  logic                      busy_o;
  logic                      done_o;
  logic        [HEAD_W-1:0]  heading_o;

  // carries a hand-computed heading alongside the command
  bit                        row_known = 1'b0;
  logic        [HEAD_W-1:0]  row_heading = '0;

  cmd_row_t pending_headings[$];
  int       mismatch_count = 0;

  // correction factors, scaled by 1e7
  int unsigned corr_factor [ROM_DEPTH] = '{
    10000000, 12731870, 12730300, 12727680, 12724020, 12719320,
    12713580, 12706810, 12699020, 12690210, 12680380, 12669560,
    12657740, 12644939, 12631160, 12616431, 12600750, 12584130,
    12566590, 12548150, 12528811, 12508590, 12487520, 12465600,
    12442850, 12419291, 12394940, 12369810, 12343930, 12317311,
    12289970, 12261920, 12233200, 12203820, 12173790, 12143151,
    12111890, 12080060, 12047660, 12014710, 11981241, 11947269,
    11912810, 11877871, 11842500, 11806690, 11770470, 11733860,
    11696870, 11659520, 11621840, 11583840, 11545531, 11506931,
    11468060, 11428930, 11389570, 11349980, 11310180, 11270190,
    11230021, 11189690, 11149200, 11108580, 11067830, 11026970,
    10986010, 10944960, 10903840, 10862660, 10821420, 10780140,
    10738831, 10697500, 10656160, 10614820, 10573480, 10532160,
    10490870, 10449600, 10408380, 10367210, 10326101, 10285040,
    10244060, 10203160, 10162340, 10121599, 10080971, 10040430,
    10000000
  };

  // headings in 1/128 degree: 0 = -y, 11520 = +x, 23040 = +y, 34560 = -x
  cmd_row_t directed_rows [NUM_DIRECTED] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'd0},
    '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b1, 16'd0},
    '{16'sd0, 16'sd0, 16'sd100, 16'sd0, 1'b1, 16'd11520},
    '{16'sd0, 16'sd0, -16'sd100, 16'sd0, 1'b1, 16'd34560},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd100, 1'b1, 16'd23040},
    '{16'sd0, 16'sd0, 16'sd0, -16'sd100, 1'b1, 16'd0},
    '{-16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 1'b1, 16'd11520},
    '{16'sd32767, 16'sd0, -16'sd32768, 16'sd0, 1'b1, 16'd34560},
    '{16'sd0, -16'sd32768, 16'sd0, 16'sd32767, 1'b1, 16'd23040},
    '{16'sd0, 16'sd32767, 16'sd0, -16'sd32768, 1'b1, 16'd0},
    '{16'sd0, 16'sd0, 16'sd5, 16'sd5, 1'b1, 16'd17280},
    '{16'sd0, 16'sd0, -16'sd5, 16'sd5, 1'b1, 16'd28800},
    '{16'sd0, 16'sd0, 16'sd5, -16'sd5, 1'b1, 16'd5760},
    '{16'sd0, 16'sd0, -16'sd5, -16'sd5, 1'b1, 16'd40320},
    '{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 1'b1, 16'd5760},
    '{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 1'b1, 16'd40320},
    // nearly straight down, just left of the axis: a full turn clamps
    '{16'sd0, 16'sd32767, -16'sd1, -16'sd32768, 1'b1, 16'd46079},
    '{16'sd0, 16'sd0, -16'sd1, -16'sd32768, 1'b1, 16'd46079},
    '{16'sd0, 16'sd0, 16'sd200, 16'sd37, 1'b0, 16'd0},
    '{16'sd10, 16'sd10, 16'sd300, -16'sd90, 1'b0, 16'd0},
    '{16'sd0, 16'sd0, -16'sd1000, 16'sd999, 1'b0, 16'd0},
    '{-16'sd5, -16'sd5, -16'sd32768, -16'sd20000, 1'b0, 16'd0},
    // table index lands exactly on a half step and rounds up
    '{16'sd0, 16'sd0, -16'sd1, 16'sd180, 1'b0, 16'd0},
    '{16'sd0, 16'sd0, 16'sd1, -16'sd181, 1'b0, 16'd0},
    '{16'sd1000, 16'sd1000, -16'sd20000, -16'sd31000, 1'b0, 16'd0}
  };

  table_corrected_vector_angle dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .from_x_i  (from_x_i),
    .from_y_i  (from_y_i),
    .to_x_i    (to_x_i),
    .to_y_i    (to_y_i),
    .done_o    (done_o),
    .heading_o (heading_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // corrected in-octant angle for small/large, large > 0
  function automatic longint unsigned octant_angle(input longint unsigned small_mag,
                                                   input longint unsigned large_mag);
    longint unsigned idx;
    longint unsigned ratio;
    longint unsigned corrected;
    idx = (180 * small_mag + large_mag) / (2 * large_mag);
    if (idx > ROM_DEPTH - 1) idx = ROM_DEPTH - 1;
    ratio = (small_mag << RATIO_FRAC) / large_mag;
    corrected = (ratio * corr_factor[idx] + 64'd5000000) / 64'd10000000;
    return (((45 * corrected) << ANGLE_FRAC) + (64'd1 << (RATIO_FRAC - 1))) >> RATIO_FRAC;
  endfunction

  function automatic logic [HEAD_W-1:0] heading_of(input logic signed [COORD_W-1:0] fx,
                                                   input logic signed [COORD_W-1:0] fy,
                                                   input logic signed [COORD_W-1:0] tx,
                                                   input logic signed [COORD_W-1:0] ty);
    longint          dx;
    longint          dy;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned quarter;
    longint unsigned offset;
    longint unsigned angle;
    dx = longint'(tx) - longint'(fx);
    dy = longint'(ty) - longint'(fy);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    quarter = 64'd90 << ANGLE_FRAC;
    if (ax > ay) begin
      offset = octant_angle(ay, ax);
      if (dx >= 0) angle = (dy >= 0) ? quarter + offset : quarter - offset;
      else         angle = (dy >= 0) ? 3 * quarter - offset : 3 * quarter + offset;
    end else if (ay == 0) begin
      angle = 0;
    end else begin
      offset = octant_angle(ax, ay);
      if (dy >= 0) angle = (dx >= 0) ? 2 * quarter - offset : 2 * quarter + offset;
      else         angle = (dx >= 0) ? offset : 4 * quarter - offset;
    end
    if (angle >= 4 * quarter) angle = 4 * quarter - 1;
    return HEAD_W'(angle);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // transfers in and results out, in one process so the order is fixed
  always @(posedge clk_i) begin
    cmd_row_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_headings.size() == 0) begin
          flag_mismatch($sformatf("unexpected result, heading %0d", heading_o));
        end else begin
          want = pending_headings.pop_front();
          if (heading_o !== want.heading)
            flag_mismatch($sformatf("heading %0d, want %0d for (%0d,%0d) -> (%0d,%0d)",
                                    heading_o, want.heading, want.fx, want.fy,
                                    want.tx, want.ty));
        end
      end
      if (start_i && !busy_o) begin
        want.fx = from_x_i;
        want.fy = from_y_i;
        want.tx = to_x_i;
        want.ty = to_y_i;
        want.known = row_known;
        want.heading = row_known ? row_heading : heading_of(from_x_i, from_y_i, to_x_i, to_y_i);
        pending_headings.push_back(want);
      end
    end
  end

  task automatic issue_cmd(input cmd_row_t row, input int idle_pct);
    start_i     <= 1'b1;
    from_x_i    <= row.fx;
    from_y_i    <= row.fy;
    to_x_i      <= row.tx;
    to_y_i      <= row.ty;
    row_known   <= row.known;
    row_heading <= row.heading;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start_i  <= 1'b0;
      from_x_i <= COORD_W'($urandom);
      to_y_i   <= COORD_W'($urandom);
      @(posedge clk_i);
    end
  endtask

  // hold off the sender until every transfer has produced its heading
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_headings.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    cmd_row_t row;
    int       idle_pct;
    int       kind;
    int       bx;
    int       by;
    int       span;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) issue_cmd(directed_rows[i], 0);
    drain_results();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        1:       idle_pct = 84;
        3:       idle_pct = 11;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < RANDOM_PHASE; n++) begin
        row.known = 1'b0;
        row.heading = '0;
        bx = $urandom;
        by = $urandom;
        row.fx = COORD_W'(bx);
        row.fy = COORD_W'(by);
        kind = $urandom_range(3);
        case (kind)
          0: begin
            row.tx = COORD_W'($urandom);
            row.ty = COORD_W'($urandom);
          end
          1: begin
            // short vectors, coincident points included
            row.tx = COORD_W'(bx + int'($urandom_range(16)) - 8);
            row.ty = COORD_W'(by + int'($urandom_range(16)) - 8);
          end
          2: begin
            // axis-aligned or diagonal, from small origins
            row.fx = COORD_W'($urandom_range(2000)) - 16'sd1000;
            row.fy = COORD_W'($urandom_range(2000)) - 16'sd1000;
            span = $urandom_range(30000);
            row.tx = row.fx + COORD_W'(span * (int'($urandom_range(2)) - 1));
            row.ty = row.fy + COORD_W'(span * (int'($urandom_range(2)) - 1));
          end
          default: begin
            // magnitudes within a few counts of a tie
            row.fx = '0;
            row.fy = '0;
            span = $urandom_range(32000, 1);
            row.tx = COORD_W'($urandom_range(1) ? span : -span);
            span = span + int'($urandom_range(4)) - 2;
            row.ty = COORD_W'($urandom_range(1) ? span : -span);
          end
        endcase
        issue_cmd(row, idle_pct);
      end
      drain_results();
    end

    repeat (LATENCY + 8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_headings.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
